/* rtl/lbs_pkg.sv */
// lbs_pkg: shared types and constants for the linear blend skinning block
// stream field widths, joint record slot layout and sequencer states
// no dependencies
package lbs_pkg;

	localparam int S_TDATA_W = 160;
	localparam int M_TDATA_W = 96;

	localparam int JOINT_W  = 5;
	localparam int SLOT_W   = 4;
	localparam int WORD_W   = 32;
	localparam int WEIGHT_W = 17;

	localparam int SLOTS_PER_JOINT = 15;
	localparam int SLOT_ROT        = 0;
	localparam int SLOT_TRANS      = 9;
	localparam int SLOT_CENTER     = 12;

	localparam int WEIGHT_FRAC = 16;
	localparam int SUM_W       = 48;

	// bit positions inside s_tdata
	localparam int JOINT_LSB  = 0;
	localparam int SLOT_LSB   = 5;
	localparam int WORD_LSB   = 9;
	localparam int VX_LSB     = 41;
	localparam int VY_LSB     = 73;
	localparam int VZ_LSB     = 105;
	localparam int WEIGHT_LSB = 137;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CENTER,
		ST_ROW,
		ST_EMIT
	} state_t;

endpackage

/* rtl/linear_blend_skinning_top.sv */
// linear_blend_skinning_top: joint table memory, one shared multiplier and
// the sequencer that accumulates weighted skinned positions
// depends on lbs_pkg
//
// usage:
//   slave stream s_*: one beat is a table load (s_tuser = 0) or a vertex
//   influence (s_tuser = 1); s_tlast marks the last influence of a vertex.
//   a load with joint and slot in range writes one word of a joint record;
//   other loads write nothing. an influence for a joint in the table keeps
//   s_tready low until it is through: the center is fetched and v - c
//   formed, then per axis t and the center are added, the three rotation
//   products and the weight product are formed and the sum is updated,
//   through the single memory read port and the single 32x33 multiplier.
//   a final influence then moves the sums into the output register. an
//   influence for a joint outside the table adds nothing.
//   master stream m_*: one beat with the saturated x, y, z sums after each
//   final influence. the output register holds while m_tready is low; the
//   block keeps accepting beats and only waits when a new result is due.
//   reset clears the sums and the sequencer; the joint table is not
//   cleared and must be loaded before use.
module linear_blend_skinning_top #(
	parameter int JOINT_COUNT   = 24,
	parameter int FRACTION_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// joint_number, word_slot, word_value, vert_x, vert_y, vert_z, blend_weight
	input  logic [lbs_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic                           s_tuser,
	// final_influence
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// skinned_x, skinned_y, skinned_z
	output logic [lbs_pkg::M_TDATA_W-1:0]  m_tdata
);
	import lbs_pkg::*;

	localparam int TABLE_DEPTH = JOINT_COUNT * SLOTS_PER_JOINT;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int ACC_W       = 66 - FRACTION_BITS;
	localparam int PROD_W      = 65;

	state_t state_q, state_d;

	logic [WORD_W-1:0]        jt_mem [TABLE_DEPTH];
	logic signed [WORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        wr_addr;
	logic                     wr_en;
	logic [SLOT_W-1:0]        rd_slot;

	logic                       accept;
	logic [JOINT_W-1:0]         in_joint;
	logic [SLOT_W-1:0]          in_slot;
	logic                       in_joint_ok;

	logic [JOINT_W-1:0]         joint_q;
	logic signed [WORD_W-1:0]   vert_q [3];
	logic [WEIGHT_W-1:0]        weight_q;
	logic                       final_q;

	logic [2:0]                 cnt_q;
	logic [1:0]                 axis_q;
	logic [1:0]                 cidx;
	logic [1:0]                 didx;

	logic signed [WORD_W-1:0]   center_q [3];
	logic signed [WORD_W-1:0]   diff_q [3];
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [PROD_W-1:0]   prod_frac;
	logic signed [PROD_W-1:0]   prod_wt;
	logic signed [WORD_W-1:0]   mul_a;
	logic signed [WORD_W:0]     mul_b;
	logic signed [WORD_W-1:0]   point;
	logic signed [WORD_W:0]     diff_wide;

	logic signed [SUM_W-1:0]    sum_q [3];
	logic signed [SUM_W+1:0]    sum_next;
	logic                       emit_fire;
	logic                       m_tvalid_q;
	logic [M_TDATA_W-1:0]       m_tdata_q;

	function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
		if (x[ACC_W-1:WORD_W-1] == {(ACC_W-WORD_W+1){x[ACC_W-1]}}) begin
			return x[WORD_W-1:0];
		end
		return x[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_diff(input logic signed [WORD_W:0] x);
		if (x[WORD_W] == x[WORD_W-1]) begin
			return x[WORD_W-1:0];
		end
		return x[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] x);
		if (x[SUM_W+1:SUM_W-1] == {3{x[SUM_W+1]}}) begin
			return x[SUM_W-1:0];
		end
		return x[SUM_W+1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_out(input logic signed [SUM_W-1:0] x);
		if (x[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){x[SUM_W-1]}}) begin
			return x[WORD_W-1:0];
		end
		return x[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

	assign in_joint    = s_tdata[JOINT_LSB +: JOINT_W];
	assign in_slot     = s_tdata[SLOT_LSB +: SLOT_W];
	assign in_joint_ok = {2'b00, in_joint} < 7'(JOINT_COUNT);
	assign accept      = s_tvalid && s_tready;
	assign emit_fire   = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// table write port
	assign wr_en   = accept && !s_tuser && in_joint_ok
		&& (in_slot < SLOT_W'(SLOTS_PER_JOINT));
	assign wr_addr = ADDR_W'(in_joint) * ADDR_W'(SLOTS_PER_JOINT) + ADDR_W'(in_slot);

	// read slot schedule
	always_comb begin
		rd_slot = '0;
		case (state_q)
			ST_CENTER: begin
				if (cnt_q < 3'd3) begin
					rd_slot = SLOT_W'(SLOT_CENTER) + SLOT_W'(cnt_q);
				end
			end
			ST_ROW: begin
				if (cnt_q == 3'd0) begin
					rd_slot = SLOT_W'(SLOT_TRANS) + SLOT_W'(axis_q);
				end else if (cnt_q < 3'd4) begin
					rd_slot = SLOT_W'(SLOT_ROT) + SLOT_W'(axis_q) * SLOT_W'(3)
						+ SLOT_W'(cnt_q - 3'd1);
				end
			end
			default: rd_slot = '0;
		endcase
	end

	assign rd_addr = ADDR_W'(joint_q) * ADDR_W'(SLOTS_PER_JOINT) + ADDR_W'(rd_slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			jt_mem[wr_addr] <= s_tdata[WORD_LSB +: WORD_W];
		end
		rd_data_q <= jt_mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser) begin
					if (in_joint_ok) begin
						state_d = ST_CENTER;
					end else if (s_tlast) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_CENTER: begin
				if (cnt_q == 3'd3) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				if (cnt_q == 3'd7 && axis_q == 2'd2) begin
					state_d = final_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shared multiplier operands
	assign cidx      = 2'(cnt_q - 3'd1);
	assign didx      = 2'(cnt_q - 3'd2);
	assign point     = sat_acc(acc_q);
	assign diff_wide = {vert_q[cidx][WORD_W-1], vert_q[cidx]}
		- {rd_data_q[WORD_W-1], rd_data_q};

	always_comb begin
		if (cnt_q == 3'd6) begin
			mul_a = point;
			mul_b = $signed({{(WORD_W+1-WEIGHT_W){1'b0}}, weight_q});
		end else begin
			mul_a = rd_data_q;
			mul_b = (WORD_W+1)'(diff_q[didx]);
		end
	end

	assign prod_frac = prod_q >>> FRACTION_BITS;
	assign prod_wt   = prod_q >>> WEIGHT_FRAC;
	assign sum_next  = (SUM_W+2)'(sum_q[axis_q]) + $signed(prod_wt[SUM_W+1:0]);

	// datapath payload
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (accept) begin
			joint_q   <= in_joint;
			vert_q[0] <= s_tdata[VX_LSB +: WORD_W];
			vert_q[1] <= s_tdata[VY_LSB +: WORD_W];
			vert_q[2] <= s_tdata[VZ_LSB +: WORD_W];
			weight_q  <= s_tdata[WEIGHT_LSB +: WEIGHT_W];
			final_q   <= s_tlast;
		end
		if (state_q == ST_CENTER && cnt_q != 3'd0) begin
			center_q[cidx] <= rd_data_q;
			diff_q[cidx]   <= sat_diff(diff_wide);
		end
		if (state_q == ST_ROW) begin
			case (cnt_q)
				3'd1: acc_q <= ACC_W'(rd_data_q);
				3'd2: acc_q <= acc_q + ACC_W'(center_q[axis_q]);
				3'd3, 3'd4, 3'd5: acc_q <= acc_q + $signed(prod_frac[ACC_W-1:0]);
				default: acc_q <= acc_q;
			endcase
		end
		if (emit_fire) begin
			m_tdata_q <= {sat_out(sum_q[2]), sat_out(sum_q[1]), sat_out(sum_q[0])};
		end
	end

	// sequencer counters, sums and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			axis_q     <= '0;
			sum_q[0]   <= '0;
			sum_q[1]   <= '0;
			sum_q[2]   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					axis_q <= '0;
				end
				ST_CENTER: begin
					cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
				end
				ST_ROW: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						sum_q[axis_q] <= sat_sum(sum_next);
						axis_q        <= axis_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						sum_q[0]   <= '0;
						sum_q[1]   <= '0;
						sum_q[2]   <= '0;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// an influence on a joint in the table starts the center fetch
	a_start_center: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser && in_joint_ok |=> state_q == ST_CENTER)
		else $error("influence did not start the sequencer");

	// moving the sums out raises valid and leaves the sums cleared
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> m_tvalid && sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0)
		else $error("emit did not load output and clear sums");

	// center phase never runs past its fourth step
	a_center_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CENTER |-> cnt_q <= 3'd3 && axis_q == 2'd0)
		else $error("center phase counter out of range");

endmodule

/* verif/tb_linear_blend_skinning_top.sv */
// tb_linear_blend_skinning_top: self-checking stream testbench for the skinning block
// queued beat driver, result monitor and a bit-exact fixed point skinning predictor
// depends on lbs_pkg and linear_blend_skinning_top
module tb_linear_blend_skinning_top;
	import lbs_pkg::*;

	localparam int JOINT_COUNT   = 24;
	localparam int FRACTION_BITS = 24;
	localparam int TABLE_DEPTH   = JOINT_COUNT * SLOTS_PER_JOINT;
	localparam int JOINT_TOP     = 2 ** JOINT_W - 1;

	localparam int ITEM_TARGET  = 1750;
	localparam int DRAIN_EVERY  = 400;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYCLES = 64;
	localparam int IDLE_PCT     = 13;
	localparam int QUIET_FROM   = 3000;
	localparam int QUIET_TO     = 9000;
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 600;

	localparam logic OP_LOAD      = 1'b0;
	localparam logic OP_INFLUENCE = 1'b1;

	localparam int unsigned ROT_SPAN  = 32'h0200_0000;
	localparam int unsigned POS_SPAN  = 32'h0800_0000;
	localparam int unsigned VERT_SPAN = 32'h1000_0000;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = 17'h1FFFF;

	localparam longint P32_MAX = 64'sh7FFF_FFFF;
	localparam longint P32_MIN = -P32_MAX - 1;
	localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	// rotation rows, translation, center for the corner-case joint
	localparam logic [WORD_W-1:0] EDGE_RECORD [SLOTS_PER_JOINT] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
		32'h0000_0000, 32'h0100_0000, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h0000_0001, 32'h0100_0000,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000
	};

	typedef struct packed {
		logic                opcode;
		logic [JOINT_W-1:0]  joint;
		logic [SLOT_W-1:0]   slot;
		logic [WORD_W-1:0]   word;
		logic [WORD_W-1:0]   vx;
		logic [WORD_W-1:0]   vy;
		logic [WORD_W-1:0]   vz;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
		logic                drain;
	} skin_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] z;
	} skinned_point_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;

	// predictor state
	logic [WORD_W-1:0] joint_words [TABLE_DEPTH];
	longint            blend_sum [3] = '{0, 0, 0};
	skinned_point_t    skinned_due [$];
	int unsigned       skinned_due_cnt  = 0;
	int unsigned       skinned_seen_cnt = 0;
	int unsigned       fail_count       = 0;

	// stimulus state
	skin_beat_t              pending_beats [$];
	skin_beat_t              beat_on_bus;
	bit [SLOTS_PER_JOINT-1:0] gen_loaded [JOINT_COUNT];
	int                      item_total = 0;
	bit                      drain_next = 1'b0;

	int unsigned cycle_count = 0;
	int          hold_left   = 0;
	bit          hold_done   = 1'b0;
	wire         quiet_window = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

	linear_blend_skinning_top #(
		.JOINT_COUNT  (JOINT_COUNT),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("linear_blend_skinning_top regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic longint table_word(int idx);
		return longint'($signed(joint_words[idx]));
	endfunction

	function automatic logic [WORD_W-1:0] sum_to_word(longint sum);
		longint s;
		s = clamp(sum, P32_MIN, P32_MAX);
		return s[WORD_W-1:0];
	endfunction

	function automatic void apply_skin_beat(skin_beat_t b);
		longint         vert [3];
		longint         diff [3];
		longint         acc;
		longint         point;
		longint         contrib;
		int             base;
		int             i;
		int             j;
		skinned_point_t res;
		if (b.opcode == OP_LOAD) begin
			if (b.joint < JOINT_COUNT && b.slot < SLOTS_PER_JOINT)
				joint_words[int'(b.joint) * SLOTS_PER_JOINT + int'(b.slot)] = b.word;
			return;
		end
		// influences outside the table add nothing but still honor the final mark
		if (b.joint < JOINT_COUNT) begin
			base = int'(b.joint) * SLOTS_PER_JOINT;
			vert[0] = longint'($signed(b.vx));
			vert[1] = longint'($signed(b.vy));
			vert[2] = longint'($signed(b.vz));
			for (i = 0; i < 3; i++)
				diff[i] = clamp(vert[i] - table_word(base + SLOT_CENTER + i), P32_MIN, P32_MAX);
			for (i = 0; i < 3; i++) begin
				acc = 0;
				for (j = 0; j < 3; j++)
					acc += (table_word(base + SLOT_ROT + i * 3 + j) * diff[j]) >>> FRACTION_BITS;
				acc += table_word(base + SLOT_TRANS + i) + table_word(base + SLOT_CENTER + i);
				point = clamp(acc, P32_MIN, P32_MAX);
				contrib = (point * longint'(b.weight)) >>> WEIGHT_FRAC;
				blend_sum[i] = clamp(blend_sum[i] + contrib, SUM_MIN, SUM_MAX);
			end
		end
		if (b.last) begin
			res.x = sum_to_word(blend_sum[0]);
			res.y = sum_to_word(blend_sum[1]);
			res.z = sum_to_word(blend_sum[2]);
			skinned_due = {skinned_due, res};
			skinned_due_cnt++;
			blend_sum = '{0, 0, 0};
		end
	endfunction

	function automatic logic [S_TDATA_W-1:0] pack_beat(skin_beat_t b);
		logic [S_TDATA_W-1:0] d;
		d = '0;
		d[JOINT_LSB +: JOINT_W]   = b.joint;
		d[SLOT_LSB +: SLOT_W]     = b.slot;
		d[WORD_LSB +: WORD_W]     = b.word;
		d[VX_LSB +: WORD_W]       = b.vx;
		d[VY_LSB +: WORD_W]       = b.vy;
		d[VZ_LSB +: WORD_W]       = b.vz;
		d[WEIGHT_LSB +: WEIGHT_W] = b.weight;
		return d;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic [WORD_W-1:0] rand_spread(int unsigned half);
		logic [WORD_W-1:0] r;
		if ($urandom_range(7) == 0)
			r = $urandom;
		else
			r = $urandom_range(2 * half) - half;
		return r;
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		logic [31:0] r;
		case ($urandom_range(9))
			0: r = {15'd0, WEIGHT_ONE};
			1: r = $urandom;
			default: r = $urandom_range(32'h10000);
		endcase
		return r[WEIGHT_W-1:0];
	endfunction

	function automatic skin_beat_t load_beat(int joint, int slot, logic [WORD_W-1:0] word,
		logic last);
		skin_beat_t  b;
		logic [31:0] r;
		r = $urandom;
		b.opcode = OP_LOAD;
		b.joint  = joint[JOINT_W-1:0];
		b.slot   = slot[SLOT_W-1:0];
		b.word   = word;
		b.vx     = $urandom;
		b.vy     = $urandom;
		b.vz     = $urandom;
		b.weight = r[WEIGHT_W-1:0];
		b.last   = last;
		b.drain  = 1'b0;
		return b;
	endfunction

	function automatic skin_beat_t influence_beat(int joint, logic [WORD_W-1:0] vx,
		logic [WORD_W-1:0] vy, logic [WORD_W-1:0] vz, logic [WEIGHT_W-1:0] weight, logic last);
		skin_beat_t  b;
		logic [31:0] r;
		r = $urandom;
		b.opcode = OP_INFLUENCE;
		b.joint  = joint[JOINT_W-1:0];
		b.slot   = r[SLOT_W-1:0];
		b.word   = $urandom;
		b.vx     = vx;
		b.vy     = vy;
		b.vz     = vz;
		b.weight = weight;
		b.last   = last;
		b.drain  = 1'b0;
		return b;
	endfunction

	// only joints with every slot written may be read by an influence
	function automatic int pick_loaded_joint();
		int j;
		do
			j = $urandom_range(JOINT_COUNT - 1);
		while (gen_loaded[j] != '1);
		return j;
	endfunction

	task automatic queue_beat(skin_beat_t b);
		b.drain = drain_next;
		drain_next = 1'b0;
		if (b.opcode == OP_LOAD && b.joint < JOINT_COUNT && b.slot < SLOTS_PER_JOINT)
			gen_loaded[b.joint][b.slot] = 1'b1;
		if (b.opcode == OP_INFLUENCE || (b.joint < JOINT_COUNT && b.slot < SLOTS_PER_JOINT))
			item_total++;
		pending_beats = {pending_beats, b};
	endtask

	task automatic load_record(int joint);
		int order [SLOTS_PER_JOINT];
		int s;
		int k;
		int tmp;
		for (s = 0; s < SLOTS_PER_JOINT; s++)
			order[s] = s;
		for (s = SLOTS_PER_JOINT - 1; s > 0; s--) begin
			k = $urandom_range(s);
			tmp = order[s];
			order[s] = order[k];
			order[k] = tmp;
		end
		for (s = 0; s < SLOTS_PER_JOINT; s++)
			queue_beat(load_beat(joint, order[s],
				(order[s] < SLOT_TRANS) ? rand_spread(ROT_SPAN) : rand_spread(POS_SPAN),
				$urandom_range(7) == 0));
	endtask

	task automatic queue_vertex();
		int                n;
		int                k;
		int                joint;
		logic [WORD_W-1:0] vx;
		logic [WORD_W-1:0] vy;
		logic [WORD_W-1:0] vz;
		n  = $urandom_range(1, 4);
		vx = rand_spread(VERT_SPAN);
		vy = rand_spread(VERT_SPAN);
		vz = rand_spread(VERT_SPAN);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(15) == 0)
				joint = $urandom_range(JOINT_COUNT, JOINT_TOP);
			else
				joint = pick_loaded_joint();
			queue_beat(influence_beat(joint, vx, vy, vz, rand_weight(), k == n - 1));
		end
	endtask

	task automatic queue_noise();
		case ($urandom_range(3))
			0: queue_beat(load_beat($urandom_range(JOINT_COUNT, JOINT_TOP),
				$urandom_range(SLOTS_PER_JOINT), $urandom, $urandom_range(1) == 1));
			1: queue_beat(load_beat($urandom_range(JOINT_COUNT - 1), SLOTS_PER_JOINT,
				$urandom, $urandom_range(1) == 1));
			2: queue_beat(load_beat(pick_loaded_joint(), $urandom_range(SLOTS_PER_JOINT - 1),
				rand_spread(ROT_SPAN), 1'b1));
			default: queue_beat(influence_beat($urandom_range(JOINT_COUNT, JOINT_TOP),
				$urandom, $urandom, $urandom, rand_weight(), $urandom_range(1) == 1));
		endcase
	endtask

	initial begin
		int s;
		int n;
		int roll;
		int next_drain;
		for (s = 0; s < JOINT_COUNT; s++)
			gen_loaded[s] = '0;

		// corner-case joint at the top of the table
		for (s = 0; s < SLOTS_PER_JOINT; s++)
			queue_beat(load_beat(JOINT_COUNT - 1, s, EDGE_RECORD[s], 1'b0));
		queue_beat(load_beat(JOINT_COUNT, 0, 32'h7FFF_FFFF, 1'b0));
		queue_beat(load_beat(5, SLOTS_PER_JOINT, 32'h8000_0000, 1'b0));
		queue_beat(load_beat(JOINT_TOP, SLOTS_PER_JOINT, 32'hFFFF_FFFF, 1'b1));
		queue_beat(influence_beat(JOINT_COUNT - 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			WEIGHT_ONE, 1'b0));
		queue_beat(influence_beat(JOINT_COUNT - 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
			WEIGHT_TOP, 1'b1));
		queue_beat(influence_beat(JOINT_TOP, 32'h0, 32'h0, 32'h0, WEIGHT_ONE, 1'b1));
		queue_beat(influence_beat(JOINT_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			WEIGHT_TOP, 1'b0));
		queue_beat(influence_beat(JOINT_COUNT - 1, 32'h0, 32'h0, 32'h0, 17'd1, 1'b0));
		queue_beat(influence_beat(JOINT_COUNT - 1, 32'h1, 32'hFFFF_FFFF, 32'h0, 17'd0, 1'b1));

		next_drain = item_total;
		while (item_total < ITEM_TARGET) begin
			if (item_total >= next_drain) begin
				drain_next = 1'b1;
				next_drain += DRAIN_EVERY;
			end
			roll = $urandom_range(99);
			if (roll < 10) begin
				load_record($urandom_range(JOINT_COUNT - 1));
			end else if (roll < 18) begin
				n = $urandom_range(1, 4);
				for (s = 0; s < n; s++)
					queue_beat(load_beat($urandom_range(JOINT_COUNT - 1),
						$urandom_range(SLOTS_PER_JOINT - 1), rand_spread(POS_SPAN), 1'b0));
			end else if (roll < 86) begin
				queue_vertex();
			end else begin
				queue_noise();
			end
		end

		while (pending_beats.size() != 0 || s_tvalid || skinned_seen_cnt != skinned_due_cnt)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && skinned_due.size() == 0)
			$display("linear_blend_skinning_top regression: pass");
		else
			$display("linear_blend_skinning_top regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				apply_skin_beat(beat_on_bus);
			if (!s_tvalid || s_tready) begin
				// a marked beat waits until every result so far has been taken
				if (pending_beats.size() != 0 && (quiet_window || $urandom_range(99) >= IDLE_PCT)
					&& !(pending_beats[0].drain && skinned_seen_cnt != skinned_due_cnt)) begin
					beat_on_bus = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= pack_beat(beat_on_bus);
					s_tuser  <= beat_on_bus.opcode;
					s_tlast  <= beat_on_bus.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	task automatic check_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (got !== want)
			report($sformatf("mismatch on %s: expected %h, got %h", field, want, got));
	endtask

	always @(posedge clk) begin
		skinned_point_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (skinned_due.size() == 0) begin
					report($sformatf("result beat with nothing expected: %h", m_tdata));
				end else begin
					want = skinned_due.pop_front();
					check_field("skinned_x", want.x, m_tdata[0 +: WORD_W]);
					check_field("skinned_y", want.y, m_tdata[WORD_W +: WORD_W]);
					check_field("skinned_z", want.z, m_tdata[2 * WORD_W +: WORD_W]);
				end
				skinned_seen_cnt <= skinned_seen_cnt + 1;
			end
			// one long back-pressure window so the block fills and stalls its input
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet_window || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// counts down the long back-pressure window
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && skinned_seen_cnt >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

endmodule
